### src/prb_pkg.sv
// Shared constants for the pulse rebinning block.
// Field widths, limits and the register reset value; no dependencies.
`default_nettype none
package prb_pkg;

  // Longest run of missing bins to fill, plus one
  localparam int unsigned MAX_GAP     = 64;
  // Samples counted per bin before further ones are ignored
  localparam int unsigned MAX_PER_BIN = 256;

  localparam int unsigned TIME_W  = 24;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned BIN_W   = TIME_W + 1;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_PER_BIN + 1);
  localparam int unsigned GAP_W   = $clog2(MAX_GAP + 1);
  localparam int unsigned SUM_W   = VAL_W + CNT_W;
  localparam int unsigned DEN_W   = (CNT_W > GAP_W) ? CNT_W : GAP_W;
  localparam int unsigned REM_W   = DEN_W + 1;
  localparam int unsigned DIV_W   = SUM_W;
  localparam int unsigned DCNT_W  = $clog2(DIV_W);
  localparam int unsigned GAPX_W  = BIN_W + 1;

  localparam int unsigned IN_DATA_W  = ((TIME_W + VAL_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((BIN_W + VAL_W + 7) / 8) * 8;

  localparam logic [SHIFT_W-1:0] BIN_SHIFT_RST = SHIFT_W'(4);
  localparam logic [SHIFT_W-1:0] MAX_SHIFT     = SHIFT_W'(8);

endpackage
`default_nettype wire

### src/pulse_rebin_interpolate.sv
// Pulse rebinning onto a uniform time grid with linear gap fill.
// Depends on prb_pkg for widths and limits; one shared restoring divider.
//
// Usage. Samples arrive on the s_axis channel: tdata carries sample_time
// (bits 23:0) and sample_value (bits 39:24), tuser carries pulse_start.
// Results leave on m_axis: tdata carries bin_index (24:0) and bin_value
// (40:25), tuser carries interpolated (bit 0) and gap_error (bit 1), tlast
// marks the last result caused by one input word. cfg_we_i writes bin_shift.
// Throughput. A sample that stays in the open bin or opens a pulse is taken
// and the block stays ready for the next. A sample that closes a bin runs the
// divider for the average (one quotient bit a cycle), a check state, then for
// every missing bin filled a divider start, the divider steps and an output
// load, and last a load of the average; s_axis_tready is low for the whole
// sequence. A finished result sits in the output register, so the next
// sample is taken while it waits. When the receiver stalls, the sequencer
// holds before each result load until the output register frees.
// Reset clears the pulse state and returns bin_shift to 4; no output pending.
`default_nettype none
module pulse_rebin_interpolate (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [prb_pkg::SHIFT_W-1:0]       cfg_wdata_i,   // bin_shift
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [23:0] sample_time, [39:24] sample_value
  input  wire logic [prb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  wire logic                              s_axis_tuser,  // [0] pulse_start
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [24:0] bin_index, [40:25] bin_value, rest zero
  output logic [prb_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  output logic [1:0]                             m_axis_tuser,  // [0] interpolated, [1] gap_error
  output logic                                   m_axis_tlast
);
  import prb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_START_INT,
    S_PUT_INT,
    S_PUT_AVG
  } state_e;

  state_e state_q;

  logic [SHIFT_W-1:0]      shift_q;
  logic                    pulse_open_q;
  logic signed [BIN_W-1:0] open_bin_q;
  logic signed [BIN_W-1:0] emitted_bin_q;
  logic signed [VAL_W-1:0] emitted_value_q;
  logic signed [SUM_W-1:0] bin_sum_q;
  logic [CNT_W-1:0]        bin_count_q;

  logic signed [BIN_W-1:0] pend_bin_q;
  logic signed [VAL_W-1:0] pend_val_q;
  logic signed [VAL_W-1:0] avg_q;
  logic signed [VAL_W-1:0] prev_q;
  logic signed [BIN_W-1:0] pb_q;
  logic [GAP_W-1:0]        dist_q;
  logic                    err_q;
  logic                    div_avg_q;

  // shared divider
  logic [DIV_W-1:0]  div_quo_q;
  logic [DEN_W-1:0]  div_rem_q;
  logic [DEN_W-1:0]  div_den_q;
  logic              div_neg_q;
  logic [DCNT_W-1:0] div_cnt_q;

  logic [BIN_W-1:0]       out_bin_q;
  logic [VAL_W-1:0]       out_val_q;
  logic                   out_interp_q;
  logic                   out_err_q;
  logic                   out_last_q;
  logic                   out_valid_q;

  // Bin index of the incoming sample, rounded half away from zero
  logic signed [TIME_W-1:0] in_time;
  logic signed [VAL_W-1:0]  in_val;
  logic [SHIFT_W-1:0]       shift_eff;
  logic [BIN_W-1:0]         t_mag;
  logic [BIN_W-1:0]         t_half;
  logic [BIN_W-1:0]         t_q;
  logic signed [BIN_W-1:0]  in_bin;

  always_comb begin
    in_time   = s_axis_tdata[TIME_W-1:0];
    in_val    = s_axis_tdata[TIME_W+VAL_W-1:TIME_W];
    shift_eff = (shift_q > MAX_SHIFT) ? MAX_SHIFT : shift_q;
    t_mag     = in_time[TIME_W-1] ? -BIN_W'(in_time) : BIN_W'(in_time);
    t_half    = (shift_eff == '0) ? '0 : (BIN_W'(1) << (shift_eff - SHIFT_W'(1)));
    t_q       = (t_mag + t_half) >> shift_eff;
    in_bin    = in_time[TIME_W-1] ? -$signed(t_q) : $signed(t_q);
  end

  // One restoring step of the divider
  logic [REM_W-1:0] rem_sh;
  logic             rem_ge;
  logic [DEN_W-1:0] div_rem_d;
  logic [DIV_W-1:0] div_quo_d;
  logic [VAL_W-1:0] div_res;

  always_comb begin
    rem_sh    = {div_rem_q, div_quo_q[DIV_W-1]};
    rem_ge    = rem_sh >= {1'b0, div_den_q};
    div_rem_d = rem_ge ? DEN_W'(rem_sh - {1'b0, div_den_q}) : rem_sh[DEN_W-1:0];
    div_quo_d = {div_quo_q[DIV_W-2:0], rem_ge};
    div_res   = div_neg_q ? -div_quo_d[VAL_W-1:0] : div_quo_d[VAL_W-1:0];
  end

  // Dividends: magnitude of the bin sum, and of avg - prev
  logic [DIV_W-1:0]        sum_mag;
  logic signed [DIV_W-1:0] diff;
  logic [DIV_W-1:0]        diff_mag;

  always_comb begin
    sum_mag  = bin_sum_q[SUM_W-1] ? -DIV_W'(bin_sum_q) : DIV_W'(bin_sum_q);
    diff     = DIV_W'(avg_q) - DIV_W'(prev_q);
    diff_mag = diff[DIV_W-1] ? -diff : diff;
  end

  logic signed [GAPX_W-1:0] gap;
  logic                     gap_fill;
  logic                     gap_long;
  logic [GAP_W-1:0]         dist_dec;

  always_comb begin
    gap      = GAPX_W'(open_bin_q) - GAPX_W'(emitted_bin_q);
    gap_long = gap > $signed(GAPX_W'(MAX_GAP));
    gap_fill = (gap > $signed(GAPX_W'(1))) && !gap_long;
    dist_dec = dist_q - GAP_W'(1);
  end

  logic in_fire;
  logic out_free;
  logic out_load;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = out_free && ((state_q == S_PUT_INT) || (state_q == S_PUT_AVG));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      shift_q         <= BIN_SHIFT_RST;
      pulse_open_q    <= 1'b0;
      open_bin_q      <= '0;
      emitted_bin_q   <= '0;
      emitted_value_q <= '0;
      bin_sum_q       <= '0;
      bin_count_q     <= '0;
      out_valid_q     <= 1'b0;
      div_cnt_q       <= '0;
      div_avg_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        shift_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser || !pulse_open_q) begin
              pulse_open_q  <= 1'b1;
              open_bin_q    <= in_bin;
              emitted_bin_q <= in_bin - BIN_W'(1);
              bin_sum_q     <= SUM_W'(in_val);
              bin_count_q   <= CNT_W'(1);
            end else if (in_bin == open_bin_q) begin
              if (bin_count_q < CNT_W'(MAX_PER_BIN)) begin
                bin_sum_q   <= bin_sum_q + SUM_W'(in_val);
                bin_count_q <= bin_count_q + CNT_W'(1);
              end
            end else begin
              // close the open bin: divide sum by count
              pend_bin_q <= in_bin;
              pend_val_q <= in_val;
              div_quo_q  <= sum_mag;
              div_rem_q  <= '0;
              div_den_q  <= DEN_W'(bin_count_q);
              div_neg_q  <= bin_sum_q[SUM_W-1];
              div_cnt_q  <= '0;
              div_avg_q  <= 1'b1;
              state_q    <= S_DIV;
            end
          end
        end

        S_DIV: begin
          div_quo_q <= div_quo_d;
          div_rem_q <= div_rem_d;
          div_cnt_q <= div_cnt_q + DCNT_W'(1);
          if (div_cnt_q == DCNT_W'(DIV_W - 1)) begin
            if (div_avg_q) begin
              avg_q   <= div_res;
              state_q <= S_CHECK;
            end else begin
              prev_q  <= prev_q + div_res;
              pb_q    <= pb_q + BIN_W'(1);
              state_q <= S_PUT_INT;
            end
          end
        end

        S_CHECK: begin
          prev_q <= emitted_value_q;
          pb_q   <= emitted_bin_q;
          dist_q <= gap[GAP_W-1:0];
          err_q  <= gap_long;
          state_q <= gap_fill ? S_START_INT : S_PUT_AVG;
        end

        S_START_INT: begin
          div_quo_q <= diff_mag;
          div_rem_q <= '0;
          div_den_q <= DEN_W'(dist_q);
          div_neg_q <= diff[DIV_W-1];
          div_cnt_q <= '0;
          div_avg_q <= 1'b0;
          state_q   <= S_DIV;
        end

        S_PUT_INT: begin
          if (out_free) begin
            out_bin_q    <= pb_q;
            out_val_q    <= prev_q;
            out_interp_q <= 1'b1;
            out_err_q    <= 1'b0;
            out_last_q   <= 1'b0;
            dist_q       <= dist_dec;
            state_q      <= (dist_dec > GAP_W'(1)) ? S_START_INT : S_PUT_AVG;
          end
        end

        S_PUT_AVG: begin
          if (out_free) begin
            out_bin_q       <= open_bin_q;
            out_val_q       <= avg_q;
            out_interp_q    <= 1'b0;
            out_err_q       <= err_q;
            out_last_q      <= 1'b1;
            // advance to the bin opened by the closing sample
            emitted_bin_q   <= open_bin_q;
            emitted_value_q <= avg_q;
            open_bin_q      <= pend_bin_q;
            bin_sum_q       <= SUM_W'(pend_val_q);
            bin_count_q     <= CNT_W'(1);
            state_q         <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_val_q, out_bin_q});
  assign m_axis_tuser  = {out_err_q, out_interp_q};
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire
